FILE: design/occ16_pkg.sv
// ----------------------------------------------------------------------------
// occ16_pkg: shared types and constants for the ones' complement checksum
// Widths, register map and the input beat structure used by every module.
// ----------------------------------------------------------------------------
`default_nettype none

package occ16_pkg;

  localparam int unsigned SumW   = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DataW  = 32;
  localparam int unsigned AddrW  = 3;

  // Register index decoded from paddr[AddrW-1:2]
  localparam logic [AddrW-3:0] RegInvertIdx = 1'b0;

  localparam logic InvertReset = 1'b1;

  typedef logic [SumW-1:0]  sum_t;
  typedef logic [ByteW-1:0] byte_t;

  // One accepted input beat
  typedef struct packed {
    byte_t data_byte;
    logic  first_byte;
    sum_t  seed_sum;
    logic  start_odd;
    logic  last_byte;
  } beat_t;

  // Ones' complement add of a 16-bit sum and a 16-bit addend, end-around carry folded
  function automatic sum_t fold_add(sum_t a, sum_t b);
    logic [SumW:0] raw;
    logic [SumW:0] folded;
    raw    = {1'b0, a} + {1'b0, b};
    folded = {1'b0, raw[SumW-1:0]} + {{SumW{1'b0}}, raw[SumW]};
    return folded[SumW-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/occ16_regs.sv
// ----------------------------------------------------------------------------
// occ16_regs: configuration register file
// APB-style slave holding the invert_result control bit.
// ----------------------------------------------------------------------------
`default_nettype none

module occ16_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [occ16_pkg::AddrW-1:0] paddr,
  input  wire logic [occ16_pkg::DataW-1:0] pwdata,
  output logic      [occ16_pkg::DataW-1:0] prdata,
  output logic                             pready,
  output logic                             invert_o
);
  import occ16_pkg::*;

  logic invert_q, invert_d;
  logic wr_en;
  logic sel_invert;

  assign sel_invert = (paddr[AddrW-1:2] == RegInvertIdx);
  assign wr_en      = psel & penable & pwrite;

  always_comb begin
    invert_d = invert_q;
    if (wr_en && sel_invert) begin
      invert_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= InvertReset;
    end else begin
      invert_q <= invert_d;
    end
  end

  // Unmapped addresses read as zero
  assign prdata   = sel_invert ? {{(DataW-1){1'b0}}, invert_q} : '0;
  assign pready   = 1'b1;
  assign invert_o = invert_q;

endmodule

`default_nettype wire

FILE: design/occ16_sum.sv
// ----------------------------------------------------------------------------
// occ16_sum: running ones' complement accumulator
// Holds the running sum and position parity; adds one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module occ16_sum (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire occ16_pkg::beat_t beat_i,
  input  wire logic             invert_i,
  output occ16_pkg::sum_t       result_o
);
  import occ16_pkg::*;

  sum_t sum_q, sum_d;
  logic odd_q, odd_d;
  sum_t base;
  logic odd_cur;
  sum_t addend;
  sum_t next_sum;

  // A first beat reloads seed and parity before its byte is added
  assign base    = beat_i.first_byte ? beat_i.seed_sum  : sum_q;
  assign odd_cur = beat_i.first_byte ? beat_i.start_odd : odd_q;

  // Even position is the high half of the word, odd is the low half
  assign addend   = odd_cur ? {{(SumW-ByteW){1'b0}}, beat_i.data_byte}
                            : {beat_i.data_byte, {(SumW-ByteW){1'b0}}};
  assign next_sum = fold_add(base, addend);

  always_comb begin
    sum_d = sum_q;
    odd_d = odd_q;
    if (step_i) begin
      sum_d = next_sum;
      odd_d = ~odd_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      odd_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      odd_q <= odd_d;
    end
  end

  assign result_o = invert_i ? ~next_sum : next_sum;

endmodule

`default_nettype wire

FILE: design/ones_complement_checksum16_top.sv
// ----------------------------------------------------------------------------
// ones_complement_checksum16_top: streaming Internet checksum
// Byte-stream 16-bit ones' complement sum with APB control of inversion.
// ----------------------------------------------------------------------------
// Each input beat carries one byte of the stream in network order. A beat
// with first_byte set loads seed_sum and the start parity (start_odd) before
// its byte is added; a byte at an even position lands in the high half of
// the 16-bit word, an odd one in the low half, and the end-around carry is
// folded at once. A beat with last_byte set produces one output beat with
// the folded sum, inverted when invert_result (register 0, byte address 0,
// reset 1) is set. The running state is kept after a last byte, so a beat
// without first_byte simply continues the sum. Throughput is one byte per
// cycle unless the input register stalls: a beat sits in the input register
// while the single 16-bit add and carry fold run, then the checksum lands
// in the output register, where output valid rises as the last byte leaves
// the input register. The input register keeps accepting while a checksum
// waits in the output register; it stalls only when it holds a last byte,
// the output register is still full and out_ready_i is low. Write
// invert_result only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module ones_complement_checksum16_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // Input stream
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  data_byte_i,
  input  wire logic                        first_byte_i,
  input  wire logic [15:0]                 seed_sum_i,
  input  wire logic                        start_odd_i,
  input  wire logic                        last_byte_i,
  // Result stream
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [15:0]                      checksum_o,
  // Configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [occ16_pkg::AddrW-1:0] paddr,
  input  wire logic [occ16_pkg::DataW-1:0] pwdata,
  output logic      [occ16_pkg::DataW-1:0] prdata,
  output logic                             pready
);
  import occ16_pkg::*;

  // Input register
  logic  in_vld_q, in_vld_d;
  beat_t beat_q, beat_d;
  // Output register
  logic  out_vld_q, out_vld_d;
  sum_t  csum_q, csum_d;

  logic  invert;
  logic  advance;
  logic  in_take;
  logic  emit;
  sum_t  result;

  occ16_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .invert_o (invert)
  );

  // Advance the held beat unless it is a last byte and the output is blocked
  assign advance = in_vld_q & (~beat_q.last_byte | ~out_vld_q | out_ready_i);
  assign emit    = advance & beat_q.last_byte;

  assign in_ready_o = ~in_vld_q | advance;
  assign in_take    = in_valid_i & in_ready_o;

  occ16_sum u_sum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .beat_i   (beat_q),
    .invert_i (invert),
    .result_o (result)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    beat_d   = beat_q;
    if (in_take) begin
      in_vld_d = 1'b1;
      beat_d   = '{data_byte:  data_byte_i,
                   first_byte: first_byte_i,
                   seed_sum:   seed_sum_i,
                   start_odd:  start_odd_i,
                   last_byte:  last_byte_i};
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    csum_d    = csum_q;
    if (emit) begin
      out_vld_d = 1'b1;
      csum_d    = result;
    end else if (out_ready_i) begin
      // Drop the beat once taken
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
    csum_q <= csum_d;
  end

  assign out_valid_o = out_vld_q;
  assign checksum_o  = csum_q;

endmodule

`default_nettype wire
